[src/yrc_pkg.sv]
// Shared types, coefficient tables and helpers for the YCbCr to RGBA converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package yrc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHROMA_MID   = 8'd128;
    localparam logic [7:0] LUMA_OFFSET  = 8'd16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_USE_BT709  = 2'd0;
    localparam logic [1:0] CFG_FULL_RANGE = 2'd1;
    localparam logic [1:0] CFG_SUBSAMPLE  = 2'd2;

    typedef struct packed {
        logic       use_bt709;
        logic       full_range;
        logic [2:0] chroma_subsampling;
    } t_cfg;

    // One pixel word as it waits between the front and the back.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb_sample;
        logic [7:0] cr_sample;
        logic       reload;
    } t_pix_cmd;

    // Coefficients in 1/256ths.
    typedef struct packed {
        logic signed [10:0] rv;
        logic signed [10:0] gu;
        logic signed [10:0] gv;
        logic signed [10:0] bu;
        logic signed [10:0] ky;
    } t_coef;

    function automatic t_coef coef_sel(input logic use_bt709, input logic full_range);
        t_coef c;
        if (full_range) begin
            c.ky = 11'sd256;
            if (use_bt709) begin
                c.rv = 11'sd403;  c.gu = -11'sd48;  c.gv = -11'sd120; c.bu = 11'sd475;
            end else begin
                c.rv = 11'sd359;  c.gu = -11'sd88;  c.gv = -11'sd183; c.bu = 11'sd454;
            end
        end else begin
            c.ky = 11'sd298;
            if (use_bt709) begin
                c.rv = 11'sd459;  c.gu = -11'sd55;  c.gv = -11'sd136; c.bu = 11'sd541;
            end else begin
                c.rv = 11'sd409;  c.gu = -11'sd100; c.gv = -11'sd208; c.bu = 11'sd516;
            end
        end
        return c;
    endfunction

    // Zero counts as one and anything above four as four.
    function automatic logic [2:0] eff_subsampling(input logic [2:0] s);
        logic [2:0] r;
        if (s == 3'd0) begin
            r = 3'd1;
        end else if (s > 3'd4) begin
            r = 3'd4;
        end else begin
            r = s;
        end
        return r;
    endfunction

    // Floor shift by eight, then clamp to 0..255.
    function automatic logic [7:0] clamp_shift(input logic signed [19:0] v);
        logic [7:0] r;
        if (v[19]) begin
            r = 8'd0;
        end else if (v[18:16] != 3'd0) begin
            r = 8'd255;
        end else begin
            r = v[15:8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/yrc_front.sv]
// Front end of the converter: accepts pixel words and marks chroma reloads.
// Depends on yrc_pkg.
`default_nettype none

module yrc_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_accept,
    input  wire [7:0]       i_luma,
    input  wire [7:0]       i_cb_sample,
    input  wire [7:0]       i_cr_sample,
    input  wire             i_row_start,
    input  wire [2:0]       i_chroma_subsampling,
    output yrc_pkg::t_pix_cmd o_cmd
);
    import yrc_pkg::*;

    logic [2:0] r_chroma_countdown;
    logic [2:0] n_chroma_countdown;
    logic       reload;

    assign reload = i_row_start || (r_chroma_countdown == 3'd0);

    always_comb begin
        if (reload) begin
            n_chroma_countdown = eff_subsampling(i_chroma_subsampling) - 3'd1;
        end else begin
            n_chroma_countdown = r_chroma_countdown - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_countdown <= 3'd0;
        end else if (i_accept) begin
            r_chroma_countdown <= n_chroma_countdown;
        end
    end

    assign o_cmd = '{luma: i_luma, cb_sample: i_cb_sample, cr_sample: i_cr_sample,
                     reload: reload};

endmodule

`default_nettype wire

[src/yrc_fifo.sv]
// Short queue of pixel words between the front and the back end.
// Depends on yrc_pkg.
`default_nettype none

module yrc_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire yrc_pkg::t_pix_cmd i_data,
    output logic                   o_full,
    input  wire                    i_pop,
    output yrc_pkg::t_pix_cmd      o_data,
    output logic                   o_empty
);
    import yrc_pkg::*;

    t_pix_cmd              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/yrc_back.sv]
// Back end of the converter: three-stage multiply, chroma term and clamp pipeline.
// Depends on yrc_pkg.
`default_nettype none

module yrc_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire yrc_pkg::t_cfg     i_cfg,
    input  wire yrc_pkg::t_pix_cmd i_cmd,
    input  wire                    i_cmd_empty,
    output logic                   o_cmd_pop,
    input  wire                    i_pop,
    output logic                   o_empty,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue
);
    import yrc_pkg::*;

    t_coef               coef;
    logic                advance;
    logic signed [8:0]   cb_c;
    logic signed [8:0]   cr_c;
    logic signed [8:0]   y_c;
    logic signed [19:0]  m_rv, m_gu, m_gv, m_bu, m_yy;
    logic signed [19:0]  sum_r, sum_g, sum_b;

    // Stage 1: products.
    logic                r_v1;
    logic                r_reload1;
    logic signed [17:0]  r_p_rv, r_p_gu, r_p_gv, r_p_bu, r_yy1;
    // Stage 2: chroma terms held across a subsampling run.
    logic                r_v2;
    logic signed [17:0]  r_red_term, r_green_term, r_blue_term, r_yy2;
    // Stage 3: result register.
    logic                r_v3;

    assign coef      = coef_sel(i_cfg.use_bt709, i_cfg.full_range);
    assign advance   = !r_v3 || i_pop;
    assign o_cmd_pop = advance && !i_cmd_empty;
    assign o_empty   = !r_v3;

    assign cb_c = $signed({1'b0, i_cmd.cb_sample}) - $signed({1'b0, CHROMA_MID});
    assign cr_c = $signed({1'b0, i_cmd.cr_sample}) - $signed({1'b0, CHROMA_MID});
    assign y_c  = i_cfg.full_range ? $signed({1'b0, i_cmd.luma})
                                   : $signed({1'b0, i_cmd.luma}) - $signed({1'b0, LUMA_OFFSET});

    assign m_rv = coef.rv * cr_c;
    assign m_gu = coef.gu * cb_c;
    assign m_gv = coef.gv * cr_c;
    assign m_bu = coef.bu * cb_c;
    assign m_yy = coef.ky * y_c;

    assign sum_r = 20'(r_yy2) + 20'(r_red_term);
    assign sum_g = 20'(r_yy2) + 20'(r_green_term);
    assign sum_b = 20'(r_yy2) + 20'(r_blue_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_red_term   <= '0;
            r_green_term <= '0;
            r_blue_term  <= '0;
        end else if (advance) begin
            r_v1 <= !i_cmd_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v1 && r_reload1) begin
                r_red_term   <= r_p_rv + 18'sd128;
                r_green_term <= r_p_gu + r_p_gv + 18'sd128;
                r_blue_term  <= r_p_bu + 18'sd128;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_reload1 <= i_cmd.reload;
            r_p_rv    <= m_rv[17:0];
            r_p_gu    <= m_gu[17:0];
            r_p_gv    <= m_gv[17:0];
            r_p_bu    <= m_bu[17:0];
            r_yy1     <= m_yy[17:0];
            r_yy2     <= r_yy1;
            o_red     <= clamp_shift(sum_r);
            o_green   <= clamp_shift(sum_g);
            o_blue    <= clamp_shift(sum_b);
        end
    end

endmodule

`default_nettype wire

[src/yuv420_to_rgba_pixel_converter.sv]
// Top level of the YCbCr to RGBA pixel converter: configuration registers and
// the front end, queue and back end. Depends on yrc_pkg, yrc_front, yrc_fifo, yrc_back.
`default_nettype none

// The converter takes one pixel word per clock while full is low (luma, the
// current Cb/Cr pair and a row-start mark) and returns one RGBA word per pixel,
// oldest first, with alpha always 255. A new set of chroma terms is formed on
// the first pixel of a row and whenever the previous set has served
// chroma_subsampling pixels (zero counting as one, above four as four); the
// Cb/Cr inputs are ignored on other pixels. Both sides behave as queues: a word
// goes in when push is high and full is low, and the word on the result ports
// is taken when pop is high and empty is low. The sustained rate is one pixel
// per clock while pop keeps pace; after leaving the four-word input queue a
// pixel passes through the multiplier, chroma term and add-and-clamp registers
// to the result ports. The back end pipeline moves as a whole, so it halts
// while a result is waiting and pop is low, and the input queue keeps taking
// pixels until it fills. Configuration (BT.709 or BT.601, full or limited range,
// subsampling factor) must be written through i_cfg_wr_en, i_cfg_index and
// i_cfg_data only while the block is idle, which the block does not enforce;
// indexes beyond the subsampling register are ignored.
module yuv420_to_rgba_pixel_converter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [1:0]  i_cfg_index,
    input  wire [2:0]  i_cfg_data,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  i_luma,
    input  wire [7:0]  i_cb_sample,
    input  wire [7:0]  i_cr_sample,
    input  wire        i_row_start,
    input  wire        pop,
    output logic       empty,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha
);
    import yrc_pkg::*;

    t_cfg     r_cfg;
    t_pix_cmd front_cmd;
    t_pix_cmd queue_cmd;
    logic     accept;
    logic     queue_empty;
    logic     queue_pop;

    // Configuration registers. The user must change these only while the block
    // is idle, which the block does not enforce, so the back end reads them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_bt709          <= 1'b1;
            r_cfg.full_range         <= 1'b0;
            r_cfg.chroma_subsampling <= 3'd2;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_USE_BT709:  r_cfg.use_bt709          <= i_cfg_data[0];
                CFG_FULL_RANGE: r_cfg.full_range         <= i_cfg_data[0];
                CFG_SUBSAMPLE:  r_cfg.chroma_subsampling <= i_cfg_data;
                default:        r_cfg                    <= r_cfg;
            endcase
        end
    end

    assign accept = push && !full;

    // The front end decides, in input order, which pixels load new chroma terms.
    yrc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_luma               (i_luma),
        .i_cb_sample          (i_cb_sample),
        .i_cr_sample          (i_cr_sample),
        .i_row_start          (i_row_start),
        .i_chroma_subsampling (r_cfg.chroma_subsampling),
        .o_cmd                (front_cmd)
    );

    yrc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_data  (queue_cmd),
        .o_empty (queue_empty)
    );

    yrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_cmd_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    assign o_alpha = ALPHA_OPAQUE;

endmodule

`default_nettype wire

[tb/yuv420_to_rgba_pixel_converter_tb.sv]
// Self-checking testbench for the YCbCr to RGBA pixel converter: directed pixels and random
// pixel streams under random idling, checked word by word against a built-in predictor.
// Depends on yrc_pkg and yuv420_to_rgba_pixel_converter.
`timescale 1ns / 1ps

module yuv420_to_rgba_pixel_converter_tb;
    import yrc_pkg::*;

    // Index past the last register; writes there must leave the block untouched.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // The scoreboard keeps its own copy of the registers and the chroma state.
    // Every accepted pixel is run through the conversion at once and the RGBA
    // word it must produce is queued; results are matched oldest first.
    class pixel_scoreboard;
        logic        use_bt709 = 1'b1;
        logic        full_range = 1'b0;
        logic [2:0]  subsampling = 3'd2;
        logic [2:0]  chroma_left = 3'd0;
        int          red_term = 0;
        int          green_term = 0;
        int          blue_term = 0;
        t_rgba       rgba_expected_q[$];
        int          mismatches = 0;

        function void write_reg(logic [1:0] index, logic [2:0] data);
            case (index)
                CFG_USE_BT709: use_bt709 = data[0];
                CFG_FULL_RANGE: full_range = data[0];
                CFG_SUBSAMPLE: subsampling = data;
                default: ;
            endcase
        endfunction

        // Floor division by 256, then saturate to a byte.
        function logic [7:0] saturate_byte(int v);
            int q;
            q = v >>> 8;
            if (q < 0) return 8'd0;
            if (q > 255) return 8'd255;
            return q[7:0];
        endfunction

        function void predict_rgba(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                   logic row_start);
            int k_rv, k_gu, k_gv, k_bu, k_y, y_off, cbs, crs, yy;
            logic [2:0] span;
            t_rgba w;
            if (full_range) begin
                k_y = 256;
                y_off = 0;
                if (use_bt709) begin
                    k_rv = 403; k_gu = -48; k_gv = -120; k_bu = 475;
                end else begin
                    k_rv = 359; k_gu = -88; k_gv = -183; k_bu = 454;
                end
            end else begin
                k_y = 298;
                y_off = -16;
                if (use_bt709) begin
                    k_rv = 459; k_gu = -55; k_gv = -136; k_bu = 541;
                end else begin
                    k_rv = 409; k_gu = -100; k_gv = -208; k_bu = 516;
                end
            end
            cbs = int'(cb) - 128;
            crs = int'(cr) - 128;
            if (row_start || chroma_left == 3'd0) begin
                red_term = k_rv * crs + 128;
                green_term = k_gu * cbs + k_gv * crs + 128;
                blue_term = k_bu * cbs + 128;
                // A factor of zero means one, and anything past four means four.
                span = subsampling;
                if (span == 3'd0) span = 3'd1;
                else if (span > 3'd4) span = 3'd4;
                chroma_left = span;
            end
            chroma_left = chroma_left - 3'd1;
            yy = (int'(luma) + y_off) * k_y;
            w.red = saturate_byte(yy + red_term);
            w.green = saturate_byte(yy + green_term);
            w.blue = saturate_byte(yy + blue_term);
            w.alpha = ALPHA_OPAQUE;
            rgba_expected_q.push_back(w);
        endfunction

        function int pending();
            return rgba_expected_q.size();
        endfunction

        task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
            mismatches++;
        endtask

        task check_rgba(t_rgba got);
            t_rgba want;
            if (rgba_expected_q.size() == 0) begin
                $display("[%0t] unexpected word %h with nothing pending", $realtime, got);
                mismatches++;
            end else begin
                want = rgba_expected_q.pop_front();
                if (got.red !== want.red) report_mismatch("red", want.red, got.red);
                if (got.green !== want.green) report_mismatch("green", want.green, got.green);
                if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
                if (got.alpha !== want.alpha) report_mismatch("alpha", want.alpha, got.alpha);
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_index;
    logic [2:0] i_cfg_data;
    logic       push;
    logic       full;
    logic [7:0] i_luma;
    logic [7:0] i_cb_sample;
    logic [7:0] i_cr_sample;
    logic       i_row_start;
    logic       pop;
    logic       empty;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic [7:0] o_alpha;

    pixel_scoreboard sb = new();

    // Set by the stimulus to ask the receiver for one long stall; the receiver
    // serves it once.
    logic hold_request = 1'b0;
    int   row_left = 0;
    int   cycle_count = 0;

    yuv420_to_rgba_pixel_converter u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .push(push),
        .full(full),
        .i_luma(i_luma),
        .i_cb_sample(i_cb_sample),
        .i_cr_sample(i_cr_sample),
        .i_row_start(i_row_start),
        .pop(pop),
        .empty(empty),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue),
        .o_alpha(o_alpha)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Everything the block accepts is observed here at the rising edge, where
    // the handshake values are still the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) sb.write_reg(i_cfg_index, i_cfg_data);
            if (push && !full) sb.predict_rgba(i_luma, i_cb_sample, i_cr_sample, i_row_start);
            if (pop && !empty) sb.check_rgba({o_red, o_green, o_blue, o_alpha});
        end
    end

    // Hard stop in case the block hangs or drops words.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver switches between pop patterns: always ready, coin flip, mostly
    // stalled, or a fixed two-of-three rhythm. On request it stalls for a long
    // stretch so that the input queue fills and full rises.
    initial begin
        int mode;
        int phase_cnt;
        bit held;
        pop = 1'b0;
        mode = 0;
        phase_cnt = 0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request && !held) begin
                pop = 1'b0;
                held = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (phase_cnt % 64 == 0) mode = $urandom_range(0, 3);
                phase_cnt++;
                case (mode)
                    0: pop = 1'b1;
                    1: pop = 1'($urandom_range(0, 1));
                    2: pop = ($urandom_range(0, 3) == 0);
                    default: pop = (phase_cnt % 3 != 0);
                endcase
            end
        end
    end

    // Offer one pixel word and hold it until the block takes it. The word stays
    // on the ports after acceptance until the next call replaces it.
    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cb,
                              input logic [7:0] cr, input logic row_start);
        @(negedge i_clk);
        push = 1'b1;
        i_luma = luma;
        i_cb_sample = cb;
        i_cr_sample = cr;
        i_row_start = row_start;
        do @(posedge i_clk); while (full);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait for every pending word to come out, so that the
    // block is idle before the registers change.
    task automatic drain();
        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [2:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Sample values lean toward the extremes, the limited-range limits and
    // mid-scale chroma so the clamps and the zero-chroma point are hit often.
    function automatic logic [7:0] pick_sample(input bit is_luma);
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return is_luma ? LUMA_OFFSET : CHROMA_MID;
            3: return is_luma ? 8'd235 : 8'd240;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed rows with a row-start mark on the first pixel, plus
    // stray or missing marks now and then. Chroma is random on every pixel, which also
    // checks that the block ignores it between reloads.
    task automatic send_random_pixel();
        logic rs;
        if (row_left == 0) begin
            row_left = $urandom_range(1, 20);
            rs = 1'b1;
        end else begin
            rs = 1'b0;
        end
        row_left--;
        if ($urandom_range(0, 9) == 0) rs = 1'($urandom_range(0, 1));
        send_pixel(pick_sample(1'b1), pick_sample(1'b0), pick_sample(1'b0), rs);
    endtask

    initial begin
        logic [2:0] cfg_table [0:4][0:2];
        int count;
        int burst;
        int n;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_USE_BT709;
        i_cfg_data = 3'd0;
        push = 1'b0;
        i_luma = 8'd0;
        i_cb_sample = 8'd0;
        i_cr_sample = 8'd0;
        i_row_start = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset settings (BT.709, limited range, pairs):
        // black and white luma, chroma at both ends and at mid-scale, a pixel
        // that reuses held terms, and row starts that cut a pair short.
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd16, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd235, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd15, 8'd255, 8'd255, 1'b0);
        drain();

        // A write to the unused index must change nothing; then BT.601, full
        // range, and a subsampling factor of zero that behaves as one. The
        // pending countdown from the pixel above runs out under the old factor.
        send_pixel(8'd100, 8'd20, 8'd230, 1'b1);
        drain();
        write_reg(CFG_UNUSED, 3'd7);
        write_reg(CFG_USE_BT709, 3'd6);
        write_reg(CFG_FULL_RANGE, 3'd1);
        write_reg(CFG_SUBSAMPLE, 3'd0);
        send_pixel(8'd200, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd77, 8'd0, 8'd255, 1'b1);
        drain();

        // Factor seven behaves as four; the upper data bits of the one-bit
        // registers are dropped.
        write_reg(CFG_USE_BT709, 3'd7);
        write_reg(CFG_SUBSAMPLE, 3'd7);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd64, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd192, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd32, 8'd10, 8'd250, 1'b0);
        drain();

        // Random part: twelve phases. The first five use fixed settings that
        // cover both ends of every register; the rest draw them at random.
        cfg_table[0] = '{3'd0, 3'd0, 3'd1};
        cfg_table[1] = '{3'd1, 3'd1, 3'd4};
        cfg_table[2] = '{3'd0, 3'd1, 3'd3};
        cfg_table[3] = '{3'd1, 3'd0, 3'd5};
        cfg_table[4] = '{3'd0, 3'd0, 3'd2};
        for (int p = 0; p < 12; p++) begin
            if (p < 5) begin
                write_reg(CFG_USE_BT709, {2'($urandom_range(0, 3)), cfg_table[p][0][0]});
                write_reg(CFG_FULL_RANGE, {2'($urandom_range(0, 3)), cfg_table[p][1][0]});
                write_reg(CFG_SUBSAMPLE, cfg_table[p][2]);
            end else begin
                write_reg(CFG_USE_BT709, 3'($urandom_range(0, 7)));
                write_reg(CFG_FULL_RANGE, 3'($urandom_range(0, 7)));
                write_reg(CFG_SUBSAMPLE, 3'($urandom_range(0, 7)));
            end
            if (p % 3 == 0) write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
            // Once the receiver stalls for a long stretch while pixels keep coming.
            if (p == 1) hold_request = 1'b1;
            n = 100;
            count = 0;
            while (count < n) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && count < n; b++) begin
                    send_random_pixel();
                    count++;
                end
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
            end
            drain();
        end

        // Give the block time to show any word it should not produce.
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/yrc_pkg.sv
src/yrc_front.sv
src/yrc_fifo.sv
src/yrc_back.sv
src/yuv420_to_rgba_pixel_converter.sv
tb/yuv420_to_rgba_pixel_converter_tb.sv
